@@ hw/rtl/erc_pkg.sv @@
// shared types and codes for the epoch reclaim tracker
package erc_pkg;

   localparam int EPOCH_W  = 64;
   localparam int HANDLE_W = 48;
   localparam int COUNT_W  = 5;
   localparam int ACTIVE_W = 19;

   localparam logic [1:0] OP_ENTER   = 2'd0;
   localparam logic [1:0] OP_EXIT    = 2'd1;
   localparam logic [1:0] OP_RETIRE  = 2'd2;
   localparam logic [1:0] OP_RECLAIM = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TABLE_FULL = 2'd1;
   localparam logic [1:0] ST_QUEUE_FULL = 2'd2;
   localparam logic [1:0] ST_GUARD_OVF  = 2'd3;

   localparam logic KIND_NOTICE  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [1:0]          operation;
      logic [EPOCH_W-1:0]  guard_epoch;
      logic [HANDLE_W-1:0] object_handle;
   } req_type;

   typedef struct packed {
      logic                kind;
      logic [1:0]          status;
      logic [EPOCH_W-1:0]  granted_epoch;
      logic [HANDLE_W-1:0] freed_handle;
      logic [COUNT_W-1:0]  freed_count;
      logic [COUNT_W-1:0]  pending_count;
      logic [ACTIVE_W-1:0] active_count;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic               used_set;
      logic               used_clr;
      logic [EPOCH_W-1:0] epoch;
   } slot_wr_type;

   typedef struct packed {
      logic                wr_en;
      logic [EPOCH_W-1:0]  epoch;
      logic [HANDLE_W-1:0] handle;
   } queue_wr_type;

endpackage

@@ hw/rtl/erc_slot_table.sv @@
// active guard table: epoch and count memories with used bits
module erc_slot_table #(
   parameter int ACTIVE_SLOTS     = 8,
   parameter int GUARD_COUNT_BITS = 16,
   parameter int SLOT_W           = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [SLOT_W-1:0]             rd_idx,
   output logic [erc_pkg::EPOCH_W-1:0]   rd_epoch,
   output logic [GUARD_COUNT_BITS-1:0]   rd_guards,
   output logic [ACTIVE_SLOTS-1:0]       used,
   input  logic [SLOT_W-1:0]             wr_idx,
   input  erc_pkg::slot_wr_type          wr_cmd,
   input  logic [GUARD_COUNT_BITS-1:0]   wr_guards
);
   import erc_pkg::*;

   logic [EPOCH_W-1:0]          epoch_mem_ff  [ACTIVE_SLOTS];
   logic [GUARD_COUNT_BITS-1:0] guards_mem_ff [ACTIVE_SLOTS];
   logic [EPOCH_W-1:0]          rd_epoch_ff;
   logic [GUARD_COUNT_BITS-1:0] rd_guards_ff;
   logic [ACTIVE_SLOTS-1:0]     used_ff, used_in;

   always_comb begin
      used_in = used_ff;
      if (wr_cmd.used_set) begin
         used_in[wr_idx] = 1'b1;
      end
      if (wr_cmd.used_clr) begin
         used_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.wr_en) begin
         epoch_mem_ff[wr_idx]  <= wr_cmd.epoch;
         guards_mem_ff[wr_idx] <= wr_guards;
      end
      rd_epoch_ff  <= epoch_mem_ff[rd_idx];
      rd_guards_ff <= guards_mem_ff[rd_idx];
   end

   assign rd_epoch  = rd_epoch_ff;
   assign rd_guards = rd_guards_ff;
   assign used      = used_ff;

endmodule

@@ hw/rtl/erc_retire_queue.sv @@
// retire queue storage: tagged handles in a circular memory
module erc_retire_queue #(
   parameter int RETIRE_DEPTH = 16,
   parameter int QUEUE_W      = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1
) (
   input  logic                         clock,
   input  logic [QUEUE_W-1:0]           rd_idx,
   output logic [erc_pkg::EPOCH_W-1:0]  rd_epoch,
   output logic [erc_pkg::HANDLE_W-1:0] rd_handle,
   input  logic [QUEUE_W-1:0]           wr_idx,
   input  erc_pkg::queue_wr_type        wr_cmd
);
   import erc_pkg::*;

   logic [EPOCH_W-1:0]  epoch_mem_ff  [RETIRE_DEPTH];
   logic [HANDLE_W-1:0] handle_mem_ff [RETIRE_DEPTH];
   logic [EPOCH_W-1:0]  rd_epoch_ff;
   logic [HANDLE_W-1:0] rd_handle_ff;

   always_ff @(posedge clock) begin
      if (wr_cmd.wr_en) begin
         epoch_mem_ff[wr_idx]  <= wr_cmd.epoch;
         handle_mem_ff[wr_idx] <= wr_cmd.handle;
      end
      rd_epoch_ff  <= epoch_mem_ff[rd_idx];
      rd_handle_ff <= handle_mem_ff[rd_idx];
   end

   assign rd_epoch  = rd_epoch_ff;
   assign rd_handle = rd_handle_ff;

endmodule

@@ hw/rtl/epoch_reclaim_tracker.sv @@
// Epoch reclaim tracker. One item is taken at a time; req_stall stays high until the item's
// closing summary beat has been loaded into the output register. All epoch compares go through
// one shared 64-bit comparator fed from registered memory reads, so each slot visit has a read
// state and a compare state. Enter and exit first scan the table for the matching slot; exit,
// retire and reclaim then scan it for the oldest guarded epoch and free queue entries from the
// head while older than that. Freed-object notice beats come first, in retirement order, and
// the summary beat with last set closes every item.
module epoch_reclaim_tracker #(
   parameter int ACTIVE_SLOTS     = 8,
   parameter int RETIRE_DEPTH     = 16,
   parameter int GUARD_COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  erc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output erc_pkg::rsp_type rsp_payload
);
   import erc_pkg::*;

   localparam int SLOT_W  = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
   localparam int QUEUE_W = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
   localparam int FILL_W  = $clog2(RETIRE_DEPTH + 1);
   localparam int SUM_W   = FILL_W + 1;

   localparam logic [SLOT_W-1:0]           SLOT_LAST  = SLOT_W'(ACTIVE_SLOTS - 1);
   localparam logic [SLOT_W-1:0]           SLOT_ONE   = SLOT_W'(1);
   localparam logic [QUEUE_W-1:0]          HEAD_LAST  = QUEUE_W'(RETIRE_DEPTH - 1);
   localparam logic [QUEUE_W-1:0]          HEAD_ONE   = QUEUE_W'(1);
   localparam logic [FILL_W-1:0]           FILL_FULL  = FILL_W'(RETIRE_DEPTH);
   localparam logic [FILL_W-1:0]           FILL_ONE   = FILL_W'(1);
   localparam logic [SUM_W-1:0]            SUM_DEPTH  = SUM_W'(RETIRE_DEPTH);
   localparam logic [GUARD_COUNT_BITS-1:0] GUARD_ONE  = GUARD_COUNT_BITS'(1);
   localparam logic [GUARD_COUNT_BITS-1:0] GUARD_MAX  = {GUARD_COUNT_BITS{1'b1}};
   localparam logic [ACTIVE_W-1:0]         TOTAL_ONE  = ACTIVE_W'(1);
   localparam logic [COUNT_W-1:0]          COUNT_ONE  = COUNT_W'(1);
   localparam logic [EPOCH_W-1:0]          EPOCH_ONE  = EPOCH_W'(1);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_FIND_RD   = 4'd1;
   localparam logic [3:0] S_FIND_CMP  = 4'd2;
   localparam logic [3:0] S_ENTER_UPD = 4'd3;
   localparam logic [3:0] S_EXIT_UPD  = 4'd4;
   localparam logic [3:0] S_RETIRE    = 4'd5;
   localparam logic [3:0] S_MIN_RD    = 4'd6;
   localparam logic [3:0] S_MIN_CMP   = 4'd7;
   localparam logic [3:0] S_Q_RD      = 4'd8;
   localparam logic [3:0] S_Q_CMP     = 4'd9;
   localparam logic [3:0] S_NOTICE    = 4'd10;
   localparam logic [3:0] S_SUMMARY   = 4'd11;

   logic [3:0]                  state_ff, state_in;
   logic [1:0]                  op_ff, op_in;
   logic [EPOCH_W-1:0]          key_ff, key_in;
   logic [HANDLE_W-1:0]         handle_ff, handle_in;
   logic [SLOT_W-1:0]           idx_ff, idx_in;
   logic                        match_ff, match_in;
   logic [SLOT_W-1:0]           match_idx_ff, match_idx_in;
   logic                        free_found_ff, free_found_in;
   logic [SLOT_W-1:0]           free_idx_ff, free_idx_in;
   logic [GUARD_COUNT_BITS-1:0] guards_ff, guards_in;
   logic [EPOCH_W-1:0]          oldest_ff, oldest_in;
   logic                        any_ff, any_in;
   logic [1:0]                  status_ff, status_in;
   logic [EPOCH_W-1:0]          granted_ff, granted_in;
   logic [COUNT_W-1:0]          freed_ff, freed_in;
   logic [EPOCH_W-1:0]          epoch_ff, epoch_in;
   logic [QUEUE_W-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [ACTIVE_W-1:0]         total_ff, total_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic [EPOCH_W-1:0]          slot_rd_epoch;
   logic [GUARD_COUNT_BITS-1:0] slot_rd_guards;
   logic [ACTIVE_SLOTS-1:0]     slot_used;
   logic [SLOT_W-1:0]           slot_wr_idx;
   logic [GUARD_COUNT_BITS-1:0] slot_wr_guards;
   slot_wr_type                 slot_cmd;
   logic [EPOCH_W-1:0]          queue_rd_epoch;
   logic [HANDLE_W-1:0]         queue_rd_handle;
   logic [QUEUE_W-1:0]          queue_tail;
   logic [SUM_W-1:0]            tail_sum;
   queue_wr_type                queue_cmd;

   logic [EPOCH_W-1:0]          cmp_a, cmp_b;
   logic                        cmp_eq, cmp_lt;
   logic                        idx_last, out_free;

   erc_slot_table #(
      .ACTIVE_SLOTS     (ACTIVE_SLOTS),
      .GUARD_COUNT_BITS (GUARD_COUNT_BITS),
      .SLOT_W           (SLOT_W)
   ) u_slot_table (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (idx_ff),
      .rd_epoch  (slot_rd_epoch),
      .rd_guards (slot_rd_guards),
      .used      (slot_used),
      .wr_idx    (slot_wr_idx),
      .wr_cmd    (slot_cmd),
      .wr_guards (slot_wr_guards)
   );

   erc_retire_queue #(
      .RETIRE_DEPTH (RETIRE_DEPTH),
      .QUEUE_W      (QUEUE_W)
   ) u_retire_queue (
      .clock     (clock),
      .rd_idx    (head_ff),
      .rd_epoch  (queue_rd_epoch),
      .rd_handle (queue_rd_handle),
      .wr_idx    (queue_tail),
      .wr_cmd    (queue_cmd)
   );

   // shared epoch comparator
   always_comb begin
      unique case (state_ff)
         S_Q_CMP: begin
            cmp_a = queue_rd_epoch;
            cmp_b = any_ff ? oldest_ff : epoch_ff;
         end
         S_MIN_CMP: begin
            cmp_a = slot_rd_epoch;
            cmp_b = oldest_ff;
         end
         default: begin
            cmp_a = slot_rd_epoch;
            cmp_b = key_ff;
         end
      endcase
   end

   assign cmp_eq = (cmp_a == cmp_b);
   assign cmp_lt = (cmp_a < cmp_b);

   assign tail_sum   = SUM_W'(head_ff) + SUM_W'(fill_ff);
   assign queue_tail = (tail_sum >= SUM_DEPTH) ? QUEUE_W'(tail_sum - SUM_DEPTH)
                                               : QUEUE_W'(tail_sum);
   assign idx_last   = (idx_ff == SLOT_LAST);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      handle_in      = handle_ff;
      idx_in         = idx_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      guards_in      = guards_ff;
      oldest_in      = oldest_ff;
      any_in         = any_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      freed_in       = freed_ff;
      epoch_in       = epoch_ff;
      head_in        = head_ff;
      fill_in        = fill_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      slot_cmd       = '0;
      slot_wr_idx    = match_idx_ff;
      slot_wr_guards = guards_ff;
      queue_cmd      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_payload.operation;
               key_in        = (req_payload.operation == OP_ENTER) ? epoch_ff
                                                                   : req_payload.guard_epoch;
               handle_in     = req_payload.object_handle;
               idx_in        = '0;
               match_in      = 1'b0;
               free_found_in = 1'b0;
               any_in        = 1'b0;
               status_in     = ST_OK;
               granted_in    = '0;
               freed_in      = '0;
               unique case (req_payload.operation)
                  OP_ENTER:   state_in = S_FIND_RD;
                  OP_EXIT:    state_in = S_FIND_RD;
                  OP_RETIRE:  state_in = S_RETIRE;
                  OP_RECLAIM: state_in = S_MIN_RD;
                  default:    state_in = S_MIN_RD;
               endcase
            end
         end
         S_FIND_RD: begin
            state_in = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (slot_used[idx_ff] && cmp_eq && !match_ff) begin
               match_in     = 1'b1;
               match_idx_in = idx_ff;
               guards_in    = slot_rd_guards;
            end
            if (!slot_used[idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (idx_last) begin
               idx_in   = '0;
               state_in = (op_ff == OP_ENTER) ? S_ENTER_UPD : S_EXIT_UPD;
            end else begin
               idx_in   = idx_ff + SLOT_ONE;
               state_in = S_FIND_RD;
            end
         end
         S_ENTER_UPD: begin
            if (match_ff) begin
               if (guards_ff == GUARD_MAX) begin
                  status_in = ST_GUARD_OVF;
               end else begin
                  slot_cmd.wr_en = 1'b1;
                  slot_cmd.epoch = key_ff;
                  slot_wr_guards = guards_ff + GUARD_ONE;
                  total_in       = total_ff + TOTAL_ONE;
                  granted_in     = key_ff;
               end
            end else if (free_found_ff) begin
               slot_cmd.wr_en    = 1'b1;
               slot_cmd.used_set = 1'b1;
               slot_cmd.epoch    = key_ff;
               slot_wr_idx       = free_idx_ff;
               slot_wr_guards    = GUARD_ONE;
               total_in          = total_ff + TOTAL_ONE;
               granted_in        = key_ff;
            end else begin
               status_in = ST_TABLE_FULL;
            end
            state_in = S_SUMMARY;
         end
         S_EXIT_UPD: begin
            if (match_ff) begin
               slot_cmd.wr_en    = 1'b1;
               slot_cmd.epoch    = key_ff;
               slot_cmd.used_clr = (guards_ff == GUARD_ONE);
               slot_wr_guards    = guards_ff - GUARD_ONE;
               total_in          = total_ff - TOTAL_ONE;
            end
            idx_in   = '0;
            any_in   = 1'b0;
            state_in = S_MIN_RD;
         end
         S_RETIRE: begin
            if (fill_ff == FILL_FULL) begin
               status_in = ST_QUEUE_FULL;
            end else begin
               queue_cmd.wr_en  = 1'b1;
               queue_cmd.epoch  = epoch_ff;
               queue_cmd.handle = handle_ff;
               fill_in          = fill_ff + FILL_ONE;
               epoch_in         = epoch_ff + EPOCH_ONE;
            end
            idx_in   = '0;
            any_in   = 1'b0;
            state_in = S_MIN_RD;
         end
         S_MIN_RD: begin
            state_in = S_MIN_CMP;
         end
         S_MIN_CMP: begin
            if (slot_used[idx_ff] && (!any_ff || cmp_lt)) begin
               oldest_in = slot_rd_epoch;
               any_in    = 1'b1;
            end
            if (idx_last) begin
               idx_in   = '0;
               state_in = S_Q_RD;
            end else begin
               idx_in   = idx_ff + SLOT_ONE;
               state_in = S_MIN_RD;
            end
         end
         S_Q_RD: begin
            state_in = (fill_ff == '0) ? S_SUMMARY : S_Q_CMP;
         end
         S_Q_CMP: begin
            state_in = cmp_lt ? S_NOTICE : S_SUMMARY;
         end
         S_NOTICE: begin
            if (out_free) begin
               rsp_in              = '0;
               rsp_in.kind         = KIND_NOTICE;
               rsp_in.freed_handle = queue_rd_handle;
               rsp_valid_in        = 1'b1;
               head_in             = (head_ff == HEAD_LAST) ? '0 : head_ff + HEAD_ONE;
               fill_in             = fill_ff - FILL_ONE;
               freed_in            = freed_ff + COUNT_ONE;
               state_in            = S_Q_RD;
            end
         end
         S_SUMMARY: begin
            if (out_free) begin
               rsp_in               = '0;
               rsp_in.kind          = KIND_SUMMARY;
               rsp_in.status        = status_ff;
               rsp_in.granted_epoch = granted_ff;
               rsp_in.freed_count   = freed_ff;
               rsp_in.pending_count = COUNT_W'(fill_ff);
               rsp_in.active_count  = total_ff;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         epoch_ff     <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         epoch_ff     <= epoch_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      idx_ff        <= idx_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      guards_ff     <= guards_in;
      oldest_ff     <= oldest_in;
      any_ff        <= any_in;
      status_ff     <= status_in;
      granted_ff    <= granted_in;
      freed_ff      <= freed_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/erc_checker.sv @@
// port-level assertions for the epoch reclaim tracker and their bind
module erc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input erc_pkg::rsp_type rsp_payload
);
   import erc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed or dropped");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not busy after accepting a beat");

   a_idle_holds_summary: assert property (@(posedge clock) disable iff (reset)
      !req_stall && rsp_valid |-> rsp_payload.last && rsp_payload.kind == KIND_SUMMARY)
      else $error("idle with a notice beat still pending");

   a_gap_after_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.last |=> !rsp_valid)
      else $error("result beat right after a closing summary");

endmodule

bind epoch_reclaim_tracker erc_checker u_erc_checker (.*);

@@ tb/sv/tb_epoch_reclaim_tracker.sv @@
`timescale 1ns / 1ps
// testbench for the epoch reclaim tracker: directed and random guard, retire and reclaim traffic
module tb_epoch_reclaim_tracker;
   import erc_pkg::*;

   localparam int ACTIVE_SLOTS     = 8;
   localparam int RETIRE_DEPTH     = 16;
   localparam int GUARD_COUNT_BITS = 16;
   localparam int GUARD_MAX        = (1 << GUARD_COUNT_BITS) - 1;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int RANDOM_ITEMS     = 116;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   bit      hurried;
   int      mismatches;
   int      rsp_hold;
   int      quiet_cycles;
   rsp_type head_beat;

   // tracker state as the testbench sees it
   logic [EPOCH_W-1:0]  epoch_now = '0;
   bit                  slot_live [ACTIVE_SLOTS];
   logic [EPOCH_W-1:0]  slot_tag [ACTIVE_SLOTS];
   int                  slot_refs [ACTIVE_SLOTS];
   logic [EPOCH_W-1:0]  retire_tag [RETIRE_DEPTH];
   logic [HANDLE_W-1:0] retire_obj [RETIRE_DEPTH];
   int                  retire_head;
   int                  retire_fill;
   rsp_type             due_beats [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   epoch_reclaim_tracker #(
      .ACTIVE_SLOTS     (ACTIVE_SLOTS),
      .RETIRE_DEPTH     (RETIRE_DEPTH),
      .GUARD_COUNT_BITS (GUARD_COUNT_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type make_item(logic [1:0] op, logic [EPOCH_W-1:0] ep,
                                         logic [HANDLE_W-1:0] obj);
      req_type item;
      item.operation     = op;
      item.guard_epoch   = ep;
      item.object_handle = obj;
      return item;
   endfunction

   function automatic void apply_tracker_op(input req_type item);
      rsp_type            beat;
      logic [EPOCH_W-1:0] oldest;
      logic [EPOCH_W-1:0] granted;
      logic [1:0]         status;
      bit                 any;
      int                 hit, spare, freed, open_guards, pos, i;
      status      = ST_OK;
      granted     = '0;
      freed       = 0;
      hit         = -1;
      spare       = -1;
      open_guards = 0;
      if (item.operation == OP_ENTER) begin
         for (i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
            if (slot_live[i] && slot_tag[i] == epoch_now) hit = i;
            if (!slot_live[i]) spare = i;
         end
         if (hit >= 0) begin
            if (slot_refs[hit] >= GUARD_MAX) begin
               status = ST_GUARD_OVF;
            end else begin
               slot_refs[hit]++;
               granted = epoch_now;
            end
         end else if (spare < 0) begin
            status = ST_TABLE_FULL;
         end else begin
            slot_live[spare] = 1'b1;
            slot_tag[spare]  = epoch_now;
            slot_refs[spare] = 1;
            granted          = epoch_now;
         end
      end else begin
         if (item.operation == OP_EXIT) begin
            for (i = 0; i < ACTIVE_SLOTS; i++)
               if (slot_live[i] && slot_tag[i] == item.guard_epoch) hit = i;
            if (hit >= 0) begin
               if (slot_refs[hit] > 0) slot_refs[hit]--;
               if (slot_refs[hit] == 0) slot_live[hit] = 1'b0;
            end
         end else if (item.operation == OP_RETIRE) begin
            if (retire_fill >= RETIRE_DEPTH) begin
               status = ST_QUEUE_FULL;
            end else begin
               pos             = (retire_head + retire_fill) % RETIRE_DEPTH;
               retire_tag[pos] = epoch_now;
               retire_obj[pos] = item.object_handle;
               retire_fill++;
               epoch_now++;
            end
         end
         // free from the head while older than the oldest guarded epoch
         oldest = epoch_now;
         any    = 1'b0;
         for (i = 0; i < ACTIVE_SLOTS; i++) begin
            if (slot_live[i] && (!any || slot_tag[i] < oldest)) begin
               oldest = slot_tag[i];
               any    = 1'b1;
            end
         end
         while (retire_fill > 0 && retire_tag[retire_head] < oldest) begin
            beat              = '0;
            beat.kind         = KIND_NOTICE;
            beat.status       = ST_OK;
            beat.freed_handle = retire_obj[retire_head];
            due_beats         = {due_beats, beat};
            retire_head = (retire_head + 1) % RETIRE_DEPTH;
            retire_fill--;
            freed++;
         end
      end
      for (i = 0; i < ACTIVE_SLOTS; i++)
         if (slot_live[i]) open_guards += slot_refs[i];
      beat               = '0;
      beat.kind          = KIND_SUMMARY;
      beat.status        = status;
      beat.granted_epoch = granted;
      beat.freed_count   = COUNT_W'(freed);
      beat.pending_count = COUNT_W'(retire_fill);
      beat.active_count  = ACTIVE_W'(open_guards);
      beat.last          = 1'b1;
      due_beats          = {due_beats, beat};
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_beats.size() == 0) begin
            $error("result beat with nothing outstanding");
            mismatches++;
         end else begin
            head_beat = due_beats.pop_front();
            check_field("kind", head_beat.kind, rsp_payload.kind);
            check_field("status", head_beat.status, rsp_payload.status);
            check_field("granted_epoch", head_beat.granted_epoch, rsp_payload.granted_epoch);
            check_field("freed_handle", head_beat.freed_handle, rsp_payload.freed_handle);
            check_field("freed_count", head_beat.freed_count, rsp_payload.freed_count);
            check_field("pending_count", head_beat.pending_count, rsp_payload.pending_count);
            check_field("active_count", head_beat.active_count, rsp_payload.active_count);
            check_field("last", head_beat.last, rsp_payload.last);
         end
         rsp_hold = hurried ? 0 : $urandom_range(0, 13);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold != 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_item(input req_type item);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      apply_tracker_op(item);
      gap = hurried ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic_flow();
      send_item(make_item(OP_RECLAIM, rand_word(), HANDLE_W'(rand_word())));
      // exit of an epoch nobody holds
      send_item(make_item(OP_EXIT, '1, '0));
      send_item(make_item(OP_ENTER, rand_word(), '1));
      send_item(make_item(OP_ENTER, '0, HANDLE_W'(rand_word())));
      // held back by the two guards
      send_item(make_item(OP_RETIRE, '1, '1));
      send_item(make_item(OP_EXIT, '0, '1));
      send_item(make_item(OP_EXIT, '0, '0));
      // no guards, freed at once
      send_item(make_item(OP_RETIRE, '0, '0));
      send_item(make_item(OP_EXIT, '0, '0));
      drain_results();
   endtask

   task automatic test_table_and_queue_full();
      logic [EPOCH_W-1:0] guard_tags [ACTIVE_SLOTS];
      int                 i;
      for (i = 0; i < ACTIVE_SLOTS; i++) begin
         guard_tags[i] = epoch_now;
         send_item(make_item(OP_ENTER, rand_word(), HANDLE_W'(rand_word())));
         send_item(make_item(OP_RETIRE, rand_word(), HANDLE_W'(rand_word())));
      end
      send_item(make_item(OP_ENTER, rand_word(), HANDLE_W'(rand_word())));
      repeat (RETIRE_DEPTH - ACTIVE_SLOTS)
         send_item(make_item(OP_RETIRE, rand_word(), HANDLE_W'(rand_word())));
      send_item(make_item(OP_RETIRE, rand_word(), HANDLE_W'(rand_word())));
      send_item(make_item(OP_RECLAIM, rand_word(), HANDLE_W'(rand_word())));
      // newest first so the final exit frees the whole queue
      for (i = ACTIVE_SLOTS - 1; i >= 0; i--)
         send_item(make_item(OP_EXIT, guard_tags[i], HANDLE_W'(rand_word())));
      drain_results();
   endtask

   task automatic test_random_traffic();
      req_type item;
      int      live_idx [$];
      int      counted, roll, i;
      bit      paused;
      counted = 0;
      paused  = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         if (counted % 25 == 0) hurried = ($urandom_range(0, 3) == 0);
         if (!paused && counted >= RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end
         live_idx.delete();
         for (i = 0; i < ACTIVE_SLOTS; i++)
            if (slot_live[i]) live_idx = {live_idx, i};
         item = make_item(OP_RECLAIM, rand_word(), HANDLE_W'(rand_word()));
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            item.operation = OP_ENTER;
         end else if (roll < 60 && live_idx.size() > 0) begin
            item.operation   = OP_EXIT;
            item.guard_epoch = slot_tag[live_idx[$urandom_range(0, live_idx.size() - 1)]];
         end else if (roll < 88) begin
            item.operation = OP_RETIRE;
         end else if (roll >= 93) begin
            // exit that matches no guard
            item.operation = OP_EXIT;
            if ($urandom_range(0, 1) == 0) item.guard_epoch = epoch_now + 1;
         end
         send_item(item);
         if (roll < 93) counted++;
      end
      hurried = 1'b0;
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basic_flow();
      test_table_and_queue_full();
      test_random_traffic();
      drain_results();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && due_beats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/erc_pkg.sv
hw/rtl/erc_slot_table.sv
hw/rtl/erc_retire_queue.sv
hw/rtl/epoch_reclaim_tracker.sv
hw/rtl/erc_checker.sv
tb/sv/tb_epoch_reclaim_tracker.sv
